// ===== sv/circle_rasterizer_to_char_canvas_core_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef CIRCLE_RASTERIZER_TO_CHAR_CANVAS_CORE_MACROS_SVH
`define CIRCLE_RASTERIZER_TO_CHAR_CANVAS_CORE_MACROS_SVH

// Clocked property, masked while reset is asserted.
`define CRCV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that must also hold during reset.
`define CRCV_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/crcv_pkg.sv =====
package crcv_pkg;

    localparam int MAX_COLS = 128;
    localparam int MAX_ROWS = 64;
    localparam int DEPTH    = MAX_COLS * MAX_ROWS;

    localparam int COL_W  = 7;   // read_col port width
    localparam int ROW_W  = 6;   // read_row port width
    localparam int ADDR_W = $clog2(DEPTH);

    localparam int CW_W   = 8;   // canvas_width register
    localparam int CH_W   = 7;   // canvas_height register
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam int CRD_W  = 9;   // center coordinates
    localparam int RAD_W  = 8;
    localparam int GLYPH_W = 8;

    localparam int X_W    = 10;  // walker x, unsigned
    localparam int Y_W    = 10;  // walker y, signed
    localparam int PT_W   = 12;  // plotted coordinate, signed
    localparam int DW     = 14;  // delta / error term, signed

    localparam logic [GLYPH_W-1:0] SPACE_GLYPH = 8'h20;

    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

    // Effective canvas size after clamping to the store.
    typedef struct packed {
        logic [CW_W-1:0] w;
        logic [CH_W-1:0] h;
    } crcv_geom_t;

    // One write into the canvas store from the circle walker.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } crcv_wr_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_COLS) + ADDR_W'(col));
    endfunction

endpackage

// ===== sv/circle_rasterizer_to_char_canvas_core.sv =====
// Flow: a read latches the RAM data at acceptance and waits in ST_RESP for the result
//   register to be free; a draw plots four points per circle step, then goes to ST_RESP.
// Throughput: one item at a time; the single write port of the canvas RAM, fed
//   one plotted point per cycle by the circle walker, sets the draw time.
// Reset: width 80, height 20; a clearing pass then fills every cell of the canvas with
//   spaces, in_ready stays low during it, configuration writes are taken throughout.
module circle_rasterizer_to_char_canvas_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_we,
    input  logic [crcv_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [crcv_pkg::CFG_DATA_W-1:0]      cfg_data,
    // item channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 op,
    input  logic signed [crcv_pkg::CRD_W-1:0]    ctr_x,
    input  logic signed [crcv_pkg::CRD_W-1:0]    ctr_y,
    input  logic [crcv_pkg::RAD_W-1:0]           radius,
    input  logic [crcv_pkg::GLYPH_W-1:0]         glyph,
    input  logic [crcv_pkg::COL_W-1:0]           read_col,
    input  logic [crcv_pkg::ROW_W-1:0]           read_row,
    // result channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [crcv_pkg::GLYPH_W-1:0]         cell_glyph,
    output logic                                 in_range,
    output logic                                 draw_done
);
    import crcv_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,   // sweeping spaces into the canvas after reset
        ST_IDLE,    // ready for the next transfer
        ST_DRAW,    // walker is plotting
        ST_RESP     // result waiting for the output register
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [CW_W-1:0]     width_reg, width_next;
    logic [CH_W-1:0]     height_reg, height_next;
    logic                is_read_reg, is_read_next;
    logic                hit_reg, hit_next;
    logic                out_valid_reg, out_valid_next;
    logic [GLYPH_W-1:0]  cell_glyph_reg, cell_glyph_next;
    logic                in_range_reg, in_range_next;
    logic                draw_done_reg, draw_done_next;
    logic [GLYPH_W-1:0]  glyph_reg;

    logic                accept;
    logic                rd_hit;
    crcv_geom_t          geom;
    crcv_wr_t            wr;
    logic                walk_done;
    logic                walk_start;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [GLYPH_W-1:0]  ram_wdata;
    logic                ram_re;
    logic [GLYPH_W-1:0]  ram_rdata;

    // clamp the configured size to the store
    assign geom.w = (width_reg > CW_W'(MAX_COLS)) ? CW_W'(MAX_COLS) : width_reg;
    assign geom.h = (height_reg > CH_W'(MAX_ROWS)) ? CH_W'(MAX_ROWS) : height_reg;

    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign walk_start = accept && (op == OP_DRAW);
    assign ram_re     = accept && (op == OP_READ);
    assign rd_hit     = ({1'b0, read_col} < geom.w) && ({1'b0, read_row} < geom.h);

    // the clearing pass owns the write port until it finishes
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = SPACE_GLYPH;
        end
        else
        begin
            ram_we    = wr.en;
            ram_waddr = wr.addr;
            ram_wdata = glyph_reg;
        end
    end

    crcv_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (cell_addr(read_row, read_col)),
        .rdata (ram_rdata)
    );

    crcv_walker u_walker (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (walk_start),
        .cx     (ctr_x),
        .cy     (ctr_y),
        .radius (radius),
        .geom   (geom),
        .wr     (wr),
        .done   (walk_done)
    );

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        is_read_next    = is_read_reg;
        hit_next        = hit_reg;
        out_valid_next  = out_valid_reg;
        cell_glyph_next = cell_glyph_reg;
        in_range_next   = in_range_reg;
        draw_done_next  = draw_done_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH:  width_next  = cfg_data[CW_W-1:0];
                REG_HEIGHT: height_next = cfg_data[CH_W-1:0];
                default:    ;
            endcase
        end

        // output register drains independently of the item side
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    is_read_next = (op == OP_READ);
                    hit_next     = rd_hit;
                    state_next   = (op == OP_READ) ? ST_RESP : ST_DRAW;
                end
            end
            ST_DRAW:
            begin
                if (walk_done)
                    state_next = ST_RESP;
            end
            ST_RESP:
            begin
                // read data is already in the RAM output register here
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    in_range_next   = is_read_reg && hit_reg;
                    draw_done_next  = !is_read_reg;
                    cell_glyph_next = (is_read_reg && hit_reg) ? ram_rdata : SPACE_GLYPH;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            width_reg      <= CW_W'(80);
            height_reg     <= CH_W'(20);
            is_read_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            cell_glyph_reg <= SPACE_GLYPH;
            in_range_reg   <= 1'b0;
            draw_done_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
            is_read_reg    <= is_read_next;
            hit_reg        <= hit_next;
            out_valid_reg  <= out_valid_next;
            cell_glyph_reg <= cell_glyph_next;
            in_range_reg   <= in_range_next;
            draw_done_reg  <= draw_done_next;
        end
    end

    // glyph for the draw in flight
    always_ff @(posedge clk)
    begin
        if (walk_start)
            glyph_reg <= glyph;
    end

    assign out_valid  = out_valid_reg;
    assign cell_glyph = cell_glyph_reg;
    assign in_range   = in_range_reg;
    assign draw_done  = draw_done_reg;

endmodule

// ===== sv/crcv_ram.sv =====
module crcv_ram (
    input  logic                           clk,
    input  logic                           we,
    input  logic [crcv_pkg::ADDR_W-1:0]    waddr,
    input  logic [crcv_pkg::GLYPH_W-1:0]   wdata,
    input  logic                           re,
    input  logic [crcv_pkg::ADDR_W-1:0]    raddr,
    output logic [crcv_pkg::GLYPH_W-1:0]   rdata
);
    import crcv_pkg::*;

    logic [GLYPH_W-1:0] mem [DEPTH];
    logic [GLYPH_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/crcv_walker.sv =====
module crcv_walker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [crcv_pkg::CRD_W-1:0] cx,
    input  logic signed [crcv_pkg::CRD_W-1:0] cy,
    input  logic [crcv_pkg::RAD_W-1:0]        radius,
    input  crcv_pkg::crcv_geom_t              geom,
    output crcv_pkg::crcv_wr_t                wr,
    output logic                              done
);
    import crcv_pkg::*;

    logic                    busy_reg, busy_next;
    logic [1:0]              phase_reg, phase_next;
    logic [X_W-1:0]          x_reg, x_next;
    logic signed [Y_W-1:0]   y_reg, y_next;
    logic signed [DW-1:0]    delta_reg, delta_next;
    logic signed [CRD_W-1:0] cx_reg, cy_reg;

    logic signed [PT_W-1:0]  px, py;
    logic                    col_ok, row_ok;
    logic signed [DW-1:0]    ys, xi, yd, err;
    logic [X_W-1:0]          x_inc;

    // point of the current phase: (cx+-x, cy+-y)
    always_comb
    begin
        if (phase_reg[1])
            px = $signed(PT_W'(cx_reg)) - $signed(PT_W'(x_reg));
        else
            px = $signed(PT_W'(cx_reg)) + $signed(PT_W'(x_reg));
        if (phase_reg[0])
            py = $signed(PT_W'(cy_reg)) - $signed(PT_W'(y_reg));
        else
            py = $signed(PT_W'(cy_reg)) + $signed(PT_W'(y_reg));
    end

    assign col_ok = !px[PT_W-1] && (px[PT_W-2:0] < (PT_W-1)'(geom.w));
    assign row_ok = !py[PT_W-1] && (py[PT_W-2:0] < (PT_W-1)'(geom.h));

    assign done    = busy_reg && y_reg[Y_W-1];
    assign wr.en   = busy_reg && !y_reg[Y_W-1] && col_ok && row_ok;
    assign wr.addr = cell_addr(py[ROW_W-1:0], px[COL_W-1:0]);

    // Bresenham circle step terms
    assign ys    = DW'(y_reg);
    assign x_inc = x_reg + X_W'(1);
    assign xi    = $signed(DW'(x_inc));
    assign yd    = ys - $signed(DW'(1));
    assign err   = ((delta_reg + ys) <<< 1) - $signed(DW'(1));

    always_comb
    begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        delta_next = delta_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            phase_next = 2'd0;
            x_next     = '0;
            y_next     = $signed(Y_W'(radius));
            delta_next = $signed(DW'(1)) - ($signed(DW'(radius)) <<< 1);
        end
        else if (busy_reg)
        begin
            if (y_reg[Y_W-1])
            begin
                busy_next = 1'b0;
            end
            else
            begin
                phase_next = phase_reg + 2'd1;
                if (phase_reg == 2'd3)
                begin
                    priority if (delta_reg < 0 && err <= 0)
                    begin
                        x_next     = x_inc;
                        delta_next = delta_reg + (xi <<< 1) + $signed(DW'(1));
                    end
                    else if (delta_reg > 0 && err > 0)
                    begin
                        y_next     = y_reg - Y_W'(1);
                        delta_next = delta_reg - (yd <<< 1) - $signed(DW'(1));
                    end
                    else
                    begin
                        x_next     = x_inc;
                        y_next     = y_reg - Y_W'(1);
                        delta_next = delta_reg + ((xi - ys) <<< 1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 2'd0;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        delta_reg <= delta_next;
        if (start)
        begin
            cx_reg <= cx;
            cy_reg <= cy;
        end
    end

endmodule

// ===== sv/crcv_checker.sv =====
`include "circle_rasterizer_to_char_canvas_core_macros.svh"

module crcv_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [crcv_pkg::GLYPH_W-1:0]      cell_glyph,
    input logic                              in_range,
    input logic                              draw_done
);
    import crcv_pkg::*;

    // a waiting result stays put
    `CRCV_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(cell_glyph), "result dropped or changed while stalled")

    // draw results carry a space and no range flag
    `CRCV_ASSERT(a_draw_fields, out_valid && draw_done |-> cell_glyph == SPACE_GLYPH && !in_range, "draw result fields wrong")

    // an out-of-range read reads as space
    `CRCV_ASSERT(a_read_miss, out_valid && !draw_done && !in_range |-> cell_glyph == SPACE_GLYPH, "missed read not space")

    // one item at a time: no transfer right after another
    `CRCV_ASSERT(a_one_in_flight, in_valid && in_ready |=> !in_ready, "second item taken while busy")

    // once reset has been seen at an edge, nothing is taken or shown
    `CRCV_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !in_ready && !out_valid, "handshake active in reset")

endmodule

bind circle_rasterizer_to_char_canvas_core crcv_checker u_crcv_checker (.*);
